@@ hdl/erma_pkg.sv @@
// ----------------------------------------------------------------------------
// erma_pkg
// Shared types and constants of the echo range moving average block.
// ----------------------------------------------------------------------------
package erma_pkg;

   // default sizes
   localparam int WINDOW_DEF   = 8;
   localparam int CHANNELS_DEF = 4;

   // distance codes
   localparam logic [9:0]  NO_ECHO       = 10'd999;
   localparam logic [9:0]  MAX_DIST      = 10'd998;
   localparam logic [15:0] TIMEOUT_RESET = 16'd20000;

   // floor(w*17/1000) as (w * RECIP_K) >> RECIP_SHIFT, exact for 16-bit w
   localparam int          RECIP_SHIFT = 30;
   localparam logic [24:0] RECIP_K     = 25'd18253614;

   // input item
   typedef struct packed {
      logic [1:0]  sensor_channel;
      logic [15:0] echo_width_us;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0] channel_out;
      logic [9:0] raw_distance_cm;
      logic [9:0] filtered_distance_cm;
      logic [3:0] valid_entries;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0] channel;
      logic [9:0] raw_cm;
   } cls_type;

   // queue handshake between front, queue and back
   typedef struct packed {
      logic push;
      logic full;
   } q_wr_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } q_rd_type;

endpackage

@@ hdl/erma_ram.sv @@
// ----------------------------------------------------------------------------
// erma_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module erma_ram #(
   parameter  int WIDTH  = 10,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/erma_front.sv @@
// ----------------------------------------------------------------------------
// erma_front
// Accepts echo widths, holds the timeout register and converts each width
// into a raw distance or the no-echo mark.
// ----------------------------------------------------------------------------
module erma_front import erma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output q_wr_type    q_wr,
   input  logic        q_full,
   output cls_type     q_data
);

   localparam int PROD_W = 16 + 25;

   logic        stg_vld_ff, stg_vld_in;
   req_type     stg_ff;
   logic [15:0] timeout_ff;
   logic        accept;
   logic [PROD_W-1:0] prod;
   logic [10:0] dist_cm;
   logic [9:0]  raw_cm;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // input stage: holds one item until the queue takes it
   assign full     = stg_vld_ff && q_full;
   assign accept   = push && !full;
   assign q_wr.push = stg_vld_ff && !q_full;
   assign q_wr.full = q_full;

   always_comb begin
      stg_vld_in = stg_vld_ff;
      if (accept) begin
         stg_vld_in = 1'b1;
      end else if (q_wr.push) begin
         stg_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= req_data;
      end
   end

   // width to centimetres by reciprocal multiply, saturated below the mark
   assign prod    = PROD_W'(stg_ff.echo_width_us) * PROD_W'(RECIP_K);
   assign dist_cm = prod[RECIP_SHIFT +: 11];

   always_comb begin
      if (stg_ff.echo_width_us == 16'd0 || stg_ff.echo_width_us > timeout_ff) begin
         raw_cm = NO_ECHO;
      end else if (dist_cm > 11'(MAX_DIST)) begin
         raw_cm = MAX_DIST;
      end else begin
         raw_cm = dist_cm[9:0];
      end
   end

   assign q_data.channel = stg_ff.sensor_channel;
   assign q_data.raw_cm  = raw_cm;

endmodule

@@ hdl/erma_queue.sv @@
// ----------------------------------------------------------------------------
// erma_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module erma_queue import erma_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   input  cls_type  wr_data,
   output logic     q_full,
   input  logic     q_pop,
   output q_rd_type q_rd,
   output cls_type  rd_data
);

   cls_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full     = (count_ff == 2'd2);
   assign q_rd.empty = (count_ff == 2'd0);
   assign q_rd.pop   = q_pop;
   assign do_push    = q_wr.push && !q_full;
   assign do_pop     = q_pop && !q_rd.empty;
   assign rd_data    = entry_ff[rd_ptr_ff];

   // pointer and fill level
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hdl/erma_back.sv @@
// ----------------------------------------------------------------------------
// erma_back
// Writes each raw distance into its channel window, sums the valid window
// entries over a sweep and divides the sum by the count one bit per cycle.
// ----------------------------------------------------------------------------
module erma_back import erma_pkg::*; #(
   parameter int WINDOW   = WINDOW_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  q_rd_type q_rd,
   input  cls_type  q_data,
   output logic     q_pop,
   input  logic     pop,
   output logic     empty,
   output rsp_type  rsp_data
);

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W  = $clog2(WINDOW * 998 + 1);
   localparam int DIV_W  = $clog2(SUM_W);
   localparam int ADDR_W = CH_W + IDX_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WRITE = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [1:0]       chan_ff, chan_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [9:0]       raw_ff, raw_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] wp_ff [CHANNELS];
   logic [IDX_W-1:0] wp_in [CHANNELS];
   logic [CNT_W-1:0] fill_ff [CHANNELS];
   logic [CNT_W-1:0] fill_in [CHANNELS];
   logic             out_vld_ff, out_vld_in;
   rsp_type          out_ff, out_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [9:0]        ram_rd_data;
   logic [9:0]        entry_val;
   logic [CNT_W:0]    rem_sh;
   logic              div_ge;
   logic              present;

   assign present = (32'(q_data.channel) < CHANNELS);

   // window store
   erma_ram #(
      .WIDTH (10),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (raw_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = (state_ff == ST_WRITE);
   assign ram_wr_addr = {ch_ff, wp_ff[ch_ff]};
   assign ram_rd_addr = {ch_ff, issue_ff[IDX_W-1:0]};

   // entries beyond the fill level read as zero; the window RAM itself has no reset
   assign entry_val = (CNT_W'(rd_idx_ff) < fill_ff[ch_ff]) ? ram_rd_data : 10'd0;

   // one restoring divide step
   assign rem_sh = {rem_ff, sum_ff[SUM_W-1]};
   assign div_ge = (rem_sh >= {1'b0, cnt_ff});

   assign q_pop = (state_ff == ST_IDLE) && !q_rd.empty;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      chan_in    = chan_ff;
      ch_in      = ch_ff;
      raw_in     = raw_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      issue_in   = issue_ff;
      div_in     = div_ff;
      rd_vld_in  = 1'b0;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;

      if (pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_rd.empty) begin
               chan_in = q_data.channel;
               ch_in   = CH_W'(q_data.channel);
               raw_in  = q_data.raw_cm;
               cnt_in  = '0;
               state_in = present ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            wp_in[ch_ff] = (wp_ff[ch_ff] == IDX_W'(WINDOW - 1)) ? '0 : wp_ff[ch_ff] + 1'b1;
            if (fill_ff[ch_ff] != CNT_W'(WINDOW)) begin
               fill_in[ch_ff] = fill_ff[ch_ff] + 1'b1;
            end
            sum_in   = '0;
            cnt_in   = '0;
            rem_in   = '0;
            issue_in = '0;
            div_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue_ff != CNT_W'(WINDOW)) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (entry_val != NO_ECHO) begin
                  sum_in = sum_ff + SUM_W'(entry_val);
                  cnt_in = cnt_ff + 1'b1;
               end
               if (rd_idx_ff == IDX_W'(WINDOW - 1)) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : CNT_W'(rem_sh);
            sum_in = {sum_ff[SUM_W-2:0], div_ge};
            div_in = div_ff + 1'b1;
            if (div_ff == DIV_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff) begin
               out_in.channel_out          = chan_ff;
               out_in.raw_distance_cm      = raw_ff;
               out_in.filtered_distance_cm = (cnt_ff == '0) ? NO_ECHO : 10'(sum_ff);
               out_in.valid_entries        = 4'(cnt_ff);
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      chan_ff   <= chan_in;
      ch_ff     <= ch_in;
      raw_ff    <= raw_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      issue_ff  <= issue_in;
      div_ff    <= div_in;
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      out_ff    <= out_in;
   end

   assign empty    = !out_vld_ff;
   assign rsp_data = out_ff;

endmodule

@@ hdl/echo_range_moving_average.sv @@
// ----------------------------------------------------------------------------
// echo_range_moving_average
// Converts ultrasonic echo widths into distances and filters each channel
// with a moving average that skips no-echo samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive req_data and raise push; the transfer happens on
//   a clock edge where push is high and full is low. Result queue side: while
//   empty is low the oldest result is on rsp_data; raise pop to take it.
//   csr_wr_en with csr_wr_data writes the echo timeout; the user must do this
//   only while idle, as the block itself does not enforce it.
// Item flow:
//   An item passes the input stage register and a queue entry; the back
//   sequencer pops it in its idle state and then steps through its write,
//   scan, divide and done states. The back takes a new item only once the
//   last one has left the done state. The window sweep through the single
//   read port of the window RAM and the one-bit-per-cycle divider, over a
//   SUM_W-bit sum (13 at the default window of 8), set the time per item.
// Reset:
//   Synchronous, active high. Clears the timeout to 20000 us, all write
//   pointers and fill levels; windows read as zero until written.
// Stalls:
//   A waiting result holds in the output register; the input stage and a
//   two-entry queue keep accepting until they fill, then full rises.
// ----------------------------------------------------------------------------
module echo_range_moving_average import erma_pkg::*; #(
   parameter int WINDOW   = WINDOW_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   cls_type  q_wr_data;
   cls_type  q_rd_data;
   logic     q_full;
   logic     q_pop;

   // front: accept and classify
   erma_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_wr        (q_wr),
      .q_full      (q_full),
      .q_data      (q_wr_data)
   );

   // decoupling queue
   erma_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rd    (q_rd),
      .rd_data (q_rd_data)
   );

   // back: window update, sum and divide
   erma_back #(
      .WINDOW   (WINDOW),
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

@@ hdl/erma_checker.sv @@
// ----------------------------------------------------------------------------
// erma_checker
// Port-level checks of the echo range moving average block.
// ----------------------------------------------------------------------------
module erma_checker import erma_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input rsp_type     rsp_data
);

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   // the input side is open right after reset
   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input blocked right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled result changed");

   // distances stay within their range
   a_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.raw_distance_cm <= NO_ECHO &&
                  rsp_data.filtered_distance_cm <= NO_ECHO))
      else $error("distance out of range");

   // the no-echo mark in the mean goes with an empty count (windows up to 15)
   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (WINDOW > 15 ||
                  ((rsp_data.valid_entries == 4'd0) ==
                   (rsp_data.filtered_distance_cm == NO_ECHO))))
      else $error("count and no-echo mean disagree");

endmodule

bind echo_range_moving_average erma_checker #(.WINDOW(WINDOW)) u_erma_checker (.*);

@@ dv/echo_range_moving_average_tb.sv @@
// ----------------------------------------------------------------------------
// echo_range_moving_average_tb
// Self-checking bench for the echo range moving average block. Echo widths
// go in through the request queue port, and a scoreboard model of the
// per-channel windows predicts each filtered result. Every result taken from
// the response port is compared field by field, in order. Directed items
// cover the no-echo, saturation, zero-timeout and window-wrap cases. A long
// response hold-off fills the block. Random traffic then runs over several
// timeout settings, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module echo_range_moving_average_tb;
   import erma_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 330;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // scoreboard copy of block state
   logic [9:0]  window_cm [CHANNELS_DEF][WINDOW_DEF];
   int          slot_ptr [CHANNELS_DEF];
   logic [15:0] timeout_us;
   rsp_type     expected_ranges[$];

   int          error_count;
   bit          sender_steady;
   bit          receiver_steady;
   bit          hold_request;

   echo_range_moving_average u_dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #8000000;
      $display("echo_range_moving_average: mismatch");
      $finish;
   end

   // model one echo: store the distance and average the channel window
   function automatic rsp_type predict_range(input logic [1:0] ch, input logic [15:0] w);
      rsp_type     r;
      int unsigned wide;
      int unsigned dist_cm;
      int unsigned sum;
      int unsigned cnt;
      wide = w;
      if (w == 16'd0 || w > timeout_us) begin
         dist_cm = NO_ECHO;
      end else begin
         dist_cm = (wide * 17) / 1000;
         if (dist_cm > MAX_DIST) begin
            dist_cm = MAX_DIST;
         end
      end
      sum = 0;
      cnt = 0;
      r.channel_out          = ch;
      r.raw_distance_cm      = 10'(dist_cm);
      r.filtered_distance_cm = NO_ECHO;
      if (ch < CHANNELS_DEF) begin
         window_cm[ch][slot_ptr[ch]] = 10'(dist_cm);
         slot_ptr[ch] = (slot_ptr[ch] + 1) % WINDOW_DEF;
         for (int i = 0; i < WINDOW_DEF; i++) begin
            if (window_cm[ch][i] != NO_ECHO) begin
               sum += window_cm[ch][i];
               cnt++;
            end
         end
         if (cnt != 0) begin
            r.filtered_distance_cm = 10'(sum / cnt);
         end
      end
      r.valid_entries = 4'(cnt);
      return r;
   endfunction

   // pick a width biased toward the current timeout boundaries
   function automatic logic [15:0] pick_width(input logic [15:0] t);
      logic [15:0] w;
      case ($urandom_range(0, 9))
         0: begin
            w = 16'd0;
         end
         1: begin
            w = (t == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(int'(t) + 1, 65535));
         end
         2: begin
            w = 16'($urandom);
         end
         3: begin
            w = t;
         end
         default: begin
            w = (t == 16'd0) ? 16'd1 : 16'($urandom_range(1, int'(t)));
         end
      endcase
      return w;
   endfunction

   // one request transfer, with a random gap in front unless the sender is steady
   task automatic send_echo(input logic [1:0] ch, input logic [15:0] w);
      req_type item;
      int      gap;
      item.sensor_channel = ch;
      item.echo_width_us  = w;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      expected_ranges.push_back(predict_range(ch, w));
   endtask

   // stop offering and wait until every result has come out
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // timeout register write, only while idle
   task automatic write_timeout(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      timeout_us  = value;
      @(posedge clock);
   endtask

   // no echo, timeout edges and field extremes at the reset timeout
   task automatic test_no_echo_limits();
      send_echo(2'd0, 16'd0);
      send_echo(2'd0, 16'd1);
      send_echo(2'd0, 16'd20000);
      send_echo(2'd0, 16'd20001);
      send_echo(2'd0, 16'hFFFF);
      send_echo(2'd1, 16'd1000);
      send_echo(2'd2, 16'd59);
      send_echo(2'd3, 16'd19999);
      wait_idle();
   endtask

   // timeout above range, distance clamps below the no-echo mark
   task automatic test_saturation();
      write_timeout(16'hFFFF);
      send_echo(2'd2, 16'd58764);
      send_echo(2'd2, 16'd58823);
      send_echo(2'd2, 16'hFFFF);
      wait_idle();
   endtask

   // zero timeout turns every width into no echo
   task automatic test_timeout_zero();
      write_timeout(16'd0);
      send_echo(2'd3, 16'd1);
      send_echo(2'd3, 16'hFFFF);
      send_echo(2'd3, 16'd0);
      wait_idle();
   endtask

   // more items than window slots on one channel so the pointer wraps
   task automatic test_window_wrap();
      write_timeout(16'd58000);
      for (int i = 0; i < 10; i++) begin
         send_echo(2'd1, (i == 4) ? 16'd0 : 16'($urandom_range(1, 58000)));
      end
      wait_idle();
   endtask

   // receiver holds off while the sender keeps going until full rises
   task automatic test_backpressure();
      sender_steady = 1'b1;
      hold_request  = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_echo(2'($urandom_range(0, 3)), pick_width(timeout_us));
      end
      sender_steady = 1'b0;
      wait_idle();
   endtask

   // random traffic over several timeout settings
   task automatic test_random_traffic();
      logic [15:0] settings [6];
      settings[0] = 16'd58000;
      settings[1] = 16'd1;
      settings[2] = 16'hFFFF;
      settings[3] = 16'($urandom_range(1, 58000));
      settings[4] = TIMEOUT_RESET;
      settings[5] = 16'($urandom);
      for (int p = 0; p < 6; p++) begin
         write_timeout(settings[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 39) == 0) begin
               sender_steady = ~sender_steady;
            end
            send_echo(2'($urandom_range(0, 3)), pick_width(timeout_us));
         end
         sender_steady = 1'b0;
         wait_idle();
      end
   endtask

   // response side: random stalls, steady stretches and the long hold-off
   initial begin
      int stall_left;
      int hold_left;
      stall_left      = 0;
      hold_left       = 0;
      receiver_steady = 1'b0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (hold_request) begin
               hold_left    = HOLD_CYCLES;
               hold_request = 1'b0;
            end
            if (pop && !empty) begin
               if ($urandom_range(0, 49) == 0) begin
                  receiver_steady = ~receiver_steady;
               end
               stall_left = receiver_steady ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0) begin
               hold_left--;
               pop <= 1'b0;
            end else if (stall_left > 0) begin
               stall_left--;
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   // compare each result transfer with the oldest prediction
   task automatic report_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && pop && !empty) begin
         if (expected_ranges.size() == 0) begin
            $display("%0t: result expected none, actual ch %0d raw %0d filt %0d cnt %0d",
                     $time, rsp_data.channel_out, rsp_data.raw_distance_cm,
                     rsp_data.filtered_distance_cm, rsp_data.valid_entries);
            error_count++;
         end else begin
            exp_rsp = expected_ranges.pop_front();
            report_field("channel_out", exp_rsp.channel_out, rsp_data.channel_out);
            report_field("raw_distance_cm", exp_rsp.raw_distance_cm,
                         rsp_data.raw_distance_cm);
            report_field("filtered_distance_cm", exp_rsp.filtered_distance_cm,
                         rsp_data.filtered_distance_cm);
            report_field("valid_entries", exp_rsp.valid_entries, rsp_data.valid_entries);
         end
      end
   end

   // test sequence
   initial begin
      error_count   = 0;
      sender_steady = 1'b0;
      hold_request  = 1'b0;
      timeout_us    = TIMEOUT_RESET;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         slot_ptr[c] = 0;
         for (int i = 0; i < WINDOW_DEF; i++) begin
            window_cm[c][i] = '0;
         end
      end
      reset       <= 1'b1;
      push        <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_echo_limits();
      test_saturation();
      test_timeout_zero();
      test_window_wrap();
      test_backpressure();
      test_random_traffic();

      if (error_count == 0) begin
         $display("echo_range_moving_average: match");
      end else begin
         $display("echo_range_moving_average: mismatch");
      end
      $finish;
   end

endmodule
